// ===== rtl/core/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the cosine similarity engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

    localparam int ELEM_W            = 16;
    localparam int PROD_W            = 32;
    localparam int ACC_W             = 48;
    localparam int SIM_W             = 16;
    localparam int Q_BITS            = 15;
    localparam int SIM_ONE           = 16384;
    localparam int ACC_SHIFT         = 30;   // largest |product| is 2^30
    localparam int RHS_SHIFT         = 28;   // 2 * 14 result fraction bits
    localparam int DEF_VECTOR_LENGTH = 512;
    localparam int DEF_QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last_elem;
    } t_in;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic                    zero_norm;
    } t_out;

    // finished accumulator set handed from front to back
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic signed [ACC_W-1:0] norm_a;
        logic signed [ACC_W-1:0] norm_b;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_DEN,
        B_MUL_RHS,
        B_CAND,
        B_CMP,
        B_DONE
    } t_bstate;

endpackage

`default_nettype wire

// ===== rtl/core/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming dot product / norm accumulation with cosine similarity output.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one element pair per transaction, pushed with push while
//    full is low. Set last_elem on the final pair of a vector.
//  - Result channel: one result per vector. While empty is low the oldest
//    result sits on o_result; pop takes it.
//  - The front end accepts one pair every cycle unless it holds a final
//    pair for a full job queue. Products are registered on accept and then
//    added to the saturating accumulators.
//  - A finished vector moves through a two-entry job queue to the quotient
//    unit: two shift-add multiplies over NW bits each, NW = clog2(L+1) + 30
//    (40 at the default length of 512), then 15 quotient bit steps. That
//    unit sets the rate for short vectors; at the default length the stream
//    stalls only when results are not popped and the queues fill.
//  - A zero norm skips the multiplies and the quotient search.
//  - When the result queue and then the job queue fill up, full rises on
//    the transaction carrying last_elem and the front end holds it.
//  - Synchronous active-low reset empties both queues and clears the
//    accumulators; no sweep is needed afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_engine #(
    parameter int VECTOR_LENGTH = cse_pkg::DEF_VECTOR_LENGTH,
    parameter int JOB_DEPTH     = cse_pkg::DEF_QUEUE_DEPTH,
    parameter int OUT_DEPTH     = cse_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire cse_pkg::t_in  i_item,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output cse_pkg::t_out      o_result
);

    localparam int JW = $bits(cse_pkg::t_job);
    localparam int OW = $bits(cse_pkg::t_out);

    // front -> job queue
    logic          job_wr, job_full, job_empty, job_rd;
    cse_pkg::t_job job_in, job_head;
    // back -> result queue
    logic          out_wr, out_full;
    cse_pkg::t_out out_data;

    cse_front #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_job_full (job_full),
        .o_job_wr   (job_wr),
        .o_job      (job_in)
    );

    // decouples accumulation of the next vector from the quotient search
    cse_fifo #(
        .WIDTH (JW),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_in),
        .i_rd    (job_rd),
        .o_rdata (job_head),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    cse_back #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_rd    (job_rd),
        .i_out_full  (out_full),
        .o_out_wr    (out_wr),
        .o_out       (out_data)
    );

    // results wait here while the receiver stalls
    cse_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata (out_data),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_full  (out_full),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cse_fifo.sv =====
// ----------------------------------------------------------------------------
// cse_fifo
// Small register FIFO, power-of-two depth.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// Element intake: registered products, saturating accumulators, job hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front #(
    parameter int VECTOR_LENGTH = cse_pkg::DEF_VECTOR_LENGTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cse_pkg::t_in  i_item,
    output logic               o_full,
    input  wire logic          i_job_full,
    output logic               o_job_wr,
    output cse_pkg::t_job      o_job
);

    localparam int AW = cse_pkg::ACC_W;
    localparam int PW = cse_pkg::PROD_W;
    localparam logic signed [AW:0] LIMIT =
        (AW + 1)'(VECTOR_LENGTH) <<< cse_pkg::ACC_SHIFT;

    logic                 r_pvalid, r_plast;
    logic signed [PW-1:0] r_pab, r_paa, r_pbb;
    logic signed [AW-1:0] r_dot, r_na, r_nb;
    logic signed [AW-1:0] s_dot, s_na, s_nb;
    logic                 advance, load;

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] acc,
        input logic signed [PW-1:0] p
    );
        logic signed [AW:0] s;
        s = {acc[AW-1], acc} + (AW + 1)'(p);
        if (s > LIMIT) begin
            s = LIMIT;
        end else if (s < -LIMIT) begin
            s = -LIMIT;
        end
        return s[AW-1:0];
    endfunction

    assign advance  = r_pvalid && (!r_plast || !i_job_full);
    assign o_full   = r_pvalid && !advance;
    assign load     = i_push && !o_full;
    assign s_dot    = sat_add(r_dot, r_pab);
    assign s_na     = sat_add(r_na, r_paa);
    assign s_nb     = sat_add(r_nb, r_pbb);
    assign o_job_wr = advance && r_plast;
    assign o_job    = '{dot: s_dot, norm_a: s_na, norm_b: s_nb};

    // operands widened first so the full 32-bit product is kept
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pab   <= PW'(i_item.elem_a) * PW'(i_item.elem_b);
            r_paa   <= PW'(i_item.elem_a) * PW'(i_item.elem_a);
            r_pbb   <= PW'(i_item.elem_b) * PW'(i_item.elem_b);
            r_plast <= i_item.last_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_dot    <= '0;
            r_na     <= '0;
            r_nb     <= '0;
        end else begin
            if (load) begin
                r_pvalid <= 1'b1;
            end else if (advance) begin
                r_pvalid <= 1'b0;
            end
            if (advance) begin
                r_dot <= r_plast ? '0 : s_dot;
                r_na  <= r_plast ? '0 : s_na;
                r_nb  <= r_plast ? '0 : s_nb;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// Quotient unit: shift-add products, then a bit-serial root-free quotient search.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back #(
    parameter int VECTOR_LENGTH = cse_pkg::DEF_VECTOR_LENGTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire cse_pkg::t_job i_job,
    output logic               o_job_rd,
    input  wire logic          i_out_full,
    output logic               o_out_wr,
    output cse_pkg::t_out      o_out
);

    // magnitude width of any saturated accumulator
    localparam int NW  = $clog2(VECTOR_LENGTH + 1) + cse_pkg::ACC_SHIFT;
    localparam int MW  = 2 * NW;
    localparam int CW  = MW + 30;
    localparam int CNW = $clog2(NW);
    localparam int QB  = cse_pkg::Q_BITS;
    localparam int SW  = cse_pkg::SIM_W;
    localparam int AW  = cse_pkg::ACC_W;

    cse_pkg::t_bstate r_state, n_state;

    logic [MW-1:0]  r_ma, n_ma;
    logic [NW-1:0]  r_mb, n_mb;
    logic [MW-1:0]  r_prod, n_prod;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [NW-1:0]  r_mag, n_mag;
    logic [MW-1:0]  r_den, n_den;
    logic [CW-1:0]  r_rhs, n_rhs;
    logic [CW-1:0]  r_s, n_s;
    logic [CW-1:0]  r_tsh, n_tsh;
    logic [CW-1:0]  r_dsq, n_dsq;
    logic [CW-1:0]  r_cand, n_cand;
    logic [QB-1:0]  r_q, n_q;
    logic [QB-1:0]  r_qbit, n_qbit;
    logic           r_neg, n_neg;
    logic           r_zero, n_zero;

    logic [MW-1:0]  prod_next;
    logic [CW-1:0]  t_acc;
    logic [AW-1:0]  dot_abs;
    logic [QB-1:0]  q_clamp;
    logic           fits;

    assign prod_next = r_prod + (r_mb[0] ? r_ma : '0);
    assign dot_abs   = i_job.dot[AW-1] ? AW'(-i_job.dot) : AW'(i_job.dot);
    assign fits      = (r_cand <= r_rhs);
    assign t_acc     = r_tsh + (fits ? (r_dsq << 1) : '0);
    assign q_clamp   = (r_q > QB'(cse_pkg::SIM_ONE)) ? QB'(cse_pkg::SIM_ONE) : r_q;

    always_comb begin
        n_state  = r_state;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_prod   = r_prod;
        n_cnt    = r_cnt;
        n_mag    = r_mag;
        n_den    = r_den;
        n_rhs    = r_rhs;
        n_s      = r_s;
        n_tsh    = r_tsh;
        n_dsq    = r_dsq;
        n_cand   = r_cand;
        n_q      = r_q;
        n_qbit   = r_qbit;
        n_neg    = r_neg;
        n_zero   = r_zero;
        o_job_rd = 1'b0;
        o_out_wr = 1'b0;
        o_out.similarity = r_neg ? -SW'(q_clamp) : SW'(q_clamp);
        o_out.zero_norm  = r_zero;

        unique case (r_state)
            cse_pkg::B_IDLE: begin
                if (!i_job_empty && !i_out_full) begin
                    o_job_rd = 1'b1;
                    n_zero   = (i_job.norm_a == '0) || (i_job.norm_b == '0);
                    n_neg    = i_job.dot[AW-1];
                    n_mag    = dot_abs[NW-1:0];
                    n_q      = '0;
                    n_ma     = MW'(i_job.norm_a[NW-1:0]);
                    n_mb     = i_job.norm_b[NW-1:0];
                    n_prod   = '0;
                    n_cnt    = CNW'(NW - 1);
                    n_state  = n_zero ? cse_pkg::B_DONE : cse_pkg::B_MUL_DEN;
                    if (n_zero) begin
                        n_neg = 1'b0;
                    end
                end
            end
            cse_pkg::B_MUL_DEN: begin
                n_prod = prod_next;
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_cnt  = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_den   = prod_next;
                    n_ma    = MW'(r_mag);
                    n_mb    = r_mag;
                    n_prod  = '0;
                    n_cnt   = CNW'(NW - 1);
                    n_state = cse_pkg::B_MUL_RHS;
                end
            end
            cse_pkg::B_MUL_RHS: begin
                n_prod = prod_next;
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_cnt  = r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    n_rhs   = CW'(prod_next) << cse_pkg::RHS_SHIFT;
                    n_dsq   = CW'(r_den) << (2 * (QB - 1));
                    n_s     = '0;
                    n_tsh   = '0;
                    n_qbit  = QB'(1) << (QB - 1);
                    n_state = cse_pkg::B_CAND;
                end
            end
            cse_pkg::B_CAND: begin
                // (q + 2^k)^2 * den = S + q*den*2^(k+1) + den*2^(2k)
                n_cand  = r_s + r_tsh + r_dsq;
                n_state = cse_pkg::B_CMP;
            end
            cse_pkg::B_CMP: begin
                if (fits) begin
                    n_s = r_cand;
                    n_q = r_q | r_qbit;
                end
                n_tsh  = t_acc >> 1;
                n_dsq  = r_dsq >> 2;
                n_qbit = r_qbit >> 1;
                n_state = r_qbit[0] ? cse_pkg::B_DONE : cse_pkg::B_CAND;
            end
            cse_pkg::B_DONE: begin
                o_out_wr = 1'b1;
                n_state  = cse_pkg::B_IDLE;
            end
            default: begin
                n_state = cse_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cse_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_prod <= n_prod;
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_den  <= n_den;
        r_rhs  <= n_rhs;
        r_s    <= n_s;
        r_tsh  <= n_tsh;
        r_dsq  <= n_dsq;
        r_cand <= n_cand;
        r_q    <= n_q;
        r_qbit <= n_qbit;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks on the cosine similarity engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire cse_pkg::t_out o_result
);

    localparam logic signed [cse_pkg::SIM_W-1:0] ONE =
        cse_pkg::SIM_W'(cse_pkg::SIM_ONE);

    // reset leaves no result and room for input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not idle after reset");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.similarity <= ONE && o_result.similarity >= -ONE))
        else $error("similarity out of range");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.zero_norm) |-> (o_result.similarity == '0))
        else $error("zero norm with nonzero similarity");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (.*);

`default_nettype wire
